/* hw/rtl/ftt_pkg.sv */
// shared types and codes for the flow table
package ftt_pkg;

   typedef enum logic [2:0] {
      KIND_SKIP   = 3'd0,
      KIND_UPD    = 3'd1,
      KIND_NEW    = 3'd2,
      KIND_FULL   = 3'd3,
      KIND_IDLE   = 3'd4,
      KIND_ACTIVE = 3'd5,
      KIND_EMPTY  = 3'd6
   } kind_type;

   localparam logic [1:0] CSR_LOCAL_IP = 2'd0;
   localparam logic [1:0] CSR_IDLE     = 2'd1;
   localparam logic [1:0] CSR_ACTIVE   = 2'd2;
   localparam logic [1:0] CSR_REFRESH  = 2'd3;

   localparam logic [39:0] BYTE_MAX = 40'hFF_FFFF_FFFF;
   localparam logic [31:0] PKT_MAX  = 32'hFFFF_FFFF;

   // contents of one flow slot
   typedef struct packed {
      logic [31:0] key_low;
      logic [31:0] key_high;
      logic [7:0]  proto;
      logic [31:0] source;
      logic [31:0] dest;
      logic [39:0] bytes;
      logic [31:0] packets;
      logic [15:0] src_tally;
      logic [15:0] dst_tally;
      logic [31:0] start;
      logic [31:0] last_seen;
   } slot_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic        lookup;
      logic        update;
      logic        create;
      logic        sweep;
      logic [31:0] key_low;
      logic [31:0] key_high;
      logic [7:0]  proto;
      logic [31:0] source;
      logic [31:0] dest;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [15:0] len;
      logic [31:0] now;
      logic [15:0] idle_limit;
      logic [15:0] active_limit;
   } cmd_type;

   // per-cell status seen by the controller
   typedef struct packed {
      logic valid;
      logic hit;
      logic expired;
      logic idle;
   } cell_stat_type;

endpackage

/* hw/rtl/ftt_cell.sv */
// one flow slot: key compare, counter update, timeout test
module ftt_cell
   import ftt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  logic          sel,
   input  logic          evict,
   output cell_stat_type stat,
   output slot_type      slot
);

   logic     valid_ff, valid_in;
   slot_type slot_ff, slot_in;
   logic     hit_ff;
   logic [31:0] idle_age, act_age;

   // timeout test against the current second
   assign idle_age = cmd.now - slot_ff.last_seen;
   assign act_age  = cmd.now - slot_ff.start;

   assign stat.valid   = valid_ff;
   assign stat.hit     = hit_ff;
   assign stat.idle    = idle_age >= {16'd0, cmd.idle_limit};
   assign stat.expired = valid_ff &&
                         (stat.idle || act_age >= {16'd0, cmd.active_limit});
   assign slot = slot_ff;

   // next slot contents
   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      if (cmd.update && sel) begin
         slot_in.bytes = (slot_ff.bytes > BYTE_MAX - {24'd0, cmd.len}) ? BYTE_MAX
                         : slot_ff.bytes + {24'd0, cmd.len};
         if (slot_ff.packets != PKT_MAX) slot_in.packets = slot_ff.packets + 32'd1;
         slot_in.last_seen = cmd.now;
         if (slot_ff.src_tally == 16'd0 || slot_ff.src_tally < cmd.sport)
            slot_in.src_tally = slot_ff.src_tally + 16'd1;
         if (slot_ff.dst_tally == 16'd0 || slot_ff.dst_tally < cmd.dport)
            slot_in.dst_tally = slot_ff.dst_tally + 16'd1;
      end else if (cmd.create && sel) begin
         valid_in          = 1'b1;
         slot_in.key_low   = cmd.key_low;
         slot_in.key_high  = cmd.key_high;
         slot_in.proto     = cmd.proto;
         slot_in.source    = cmd.source;
         slot_in.dest      = cmd.dest;
         slot_in.bytes     = {24'd0, cmd.len};
         slot_in.packets   = 32'd1;
         slot_in.src_tally = 16'd1;
         slot_in.dst_tally = 16'd1;
         slot_in.start     = cmd.now;
         slot_in.last_seen = cmd.now;
      end else if (evict) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= cmd.lookup && valid_ff && slot_ff.key_low == cmd.key_low &&
                     slot_ff.key_high == cmd.key_high && slot_ff.proto == cmd.proto;
      end
      slot_ff <= slot_in;
   end

endmodule

/* hw/rtl/flow_table_with_timeouts_top.sv */
// flow table top level: controller over a row of flow cells
//
//  channel | ports                      | handshake
//  input   | req_*, start / busy        | accepted when start && !busy
//  result  | rsp_*, rsp_strobe          | one cycle per result, no stall
//  config  | csr_we, csr_index, csr_data| written when csr_we
//
// a skipped packet or a tick without sweep keeps busy low; its result, if any,
// shows in the next cycle. a local packet holds busy through registered
// compare in all cells, decide, cell write and result register; the result
// shows right after. a dropped packet holds busy through compare and decide.
// a sweep visits one slot per cycle, then an end state. reset clears all
// valid bits.
module flow_table_with_timeouts_top
   import ftt_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_dest_address,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   input  logic [15:0] req_packet_bytes,
   input  logic [7:0]  req_proto,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_flow_source,
   output logic [31:0] rsp_flow_dest,
   output logic [7:0]  rsp_flow_proto,
   output logic [39:0] rsp_byte_total,
   output logic [31:0] rsp_packet_total,
   output logic [15:0] rsp_src_port_tally,
   output logic [15:0] rsp_dst_port_tally,
   output logic [31:0] rsp_start_second,
   output logic [31:0] rsp_duration_seconds,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int MAX_EVICT = 32;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOOK, ST_DECIDE, ST_WRITE, ST_EMIT, ST_SWEEP, ST_SWEND
   } state_type;

   state_type     state_ff;
   logic [31:0]   local_ip_ff;
   logic [15:0]   idle_ff, active_ff, refresh_ff, ticks_ff;
   logic [31:0]   now_ff;
   logic [31:0]   klo_ff, khi_ff, src_ff, dst_ff;
   logic [15:0]   sp_ff, dp_ff, len_ff;
   logic [7:0]    pr_ff;
   logic [IW-1:0] idx_ff;
   logic          any_ff;
   logic [5:0]    cnt_ff;
   logic          upd_ff, new_ff;

   cmd_type       cmd;
   cell_stat_type stat [TABLE_DEPTH];
   slot_type      slots [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] sel, evict, hit_v, free_v, exp_v;

   logic [IW-1:0] hit_idx, free_idx;
   logic          hit_any, free_any;
   slot_type      cur;
   logic [15:0]   period, ticks_nx;
   logic          eligible, last_slot, take, more_after;

   // per-cell control
   always_comb begin
      cmd              = '0;
      cmd.lookup       = state_ff == ST_LOOK;
      cmd.update       = upd_ff;
      cmd.create       = new_ff;
      cmd.sweep        = state_ff == ST_SWEEP;
      cmd.key_low      = klo_ff;
      cmd.key_high     = khi_ff;
      cmd.proto        = pr_ff;
      cmd.source       = src_ff;
      cmd.dest         = dst_ff;
      cmd.sport        = sp_ff;
      cmd.dport        = dp_ff;
      cmd.len          = len_ff;
      cmd.now          = now_ff;
      cmd.idle_limit   = idle_ff;
      cmd.active_limit = active_ff;
   end

   // the row of cells
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      assign sel[g]    = idx_ff == IW'(g);
      assign hit_v[g]  = stat[g].hit;
      assign free_v[g] = !stat[g].valid;
      assign exp_v[g]  = stat[g].expired;
      ftt_cell u_cell (
         .clock (clock), .reset (reset), .cmd (cmd), .sel (sel[g]),
         .evict (evict[g]), .stat (stat[g]), .slot (slots[g])
      );
   end

   // lowest hit and lowest free slot
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      hit_any  = 1'b0;
      free_any = 1'b0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (hit_v[i]) begin
            hit_idx = i[IW-1:0];
            hit_any = 1'b1;
         end
         if (free_v[i]) begin
            free_idx = i[IW-1:0];
            free_any = 1'b1;
         end
      end
   end

   // any expired slot above the one being visited
   always_comb begin
      more_after = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (exp_v[i] && IW'(i) > idx_ff) more_after = 1'b1;
      end
   end

   assign cur       = slots[idx_ff];
   assign eligible  = stat[idx_ff].expired;
   assign take      = eligible && cnt_ff != 6'(MAX_EVICT);
   assign last_slot = idx_ff == IW'(TABLE_DEPTH - 1);
   assign evict     = (state_ff == ST_SWEEP && take) ? sel : '0;
   assign period    = (refresh_ff == 16'd0) ? 16'd1 : refresh_ff;
   assign ticks_nx  = ticks_ff + 16'd1;
   assign busy      = state_ff != ST_IDLE;

   // controller and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         local_ip_ff <= '0;
         idle_ff     <= 16'd60;
         active_ff   <= 16'd300;
         refresh_ff  <= 16'd5;
         ticks_ff    <= '0;
         now_ff      <= '0;
         rsp_strobe  <= 1'b0;
         upd_ff      <= 1'b0;
         new_ff      <= 1'b0;
      end else begin
         rsp_strobe <= 1'b0;
         upd_ff     <= 1'b0;
         new_ff     <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_LOCAL_IP: local_ip_ff <= csr_data;
               CSR_IDLE:     idle_ff     <= csr_data[15:0];
               CSR_ACTIVE:   active_ff   <= csr_data[15:0];
               CSR_REFRESH:  refresh_ff  <= csr_data[15:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  src_ff <= req_source_address;
                  dst_ff <= req_dest_address;
                  sp_ff  <= req_source_port;
                  dp_ff  <= req_dest_port;
                  len_ff <= req_packet_bytes;
                  pr_ff  <= req_proto;
                  klo_ff <= (req_source_address < req_dest_address)
                            ? req_source_address : req_dest_address;
                  khi_ff <= (req_source_address < req_dest_address)
                            ? req_dest_address : req_source_address;
                  if (!req_command) begin
                     if (req_dest_address != local_ip_ff) begin
                        rsp_strobe <= 1'b1;
                        rsp_kind   <= KIND_SKIP;
                        rsp_flow_source <= '0; rsp_flow_dest <= '0;
                        rsp_flow_proto <= '0; rsp_byte_total <= '0;
                        rsp_packet_total <= '0; rsp_src_port_tally <= '0;
                        rsp_dst_port_tally <= '0; rsp_start_second <= '0;
                        rsp_duration_seconds <= '0;
                        rsp_last   <= 1'b1;
                     end else begin
                        state_ff <= ST_LOOK;
                     end
                  end else begin
                     now_ff <= now_ff + 32'd1;
                     if (ticks_nx >= period) begin
                        ticks_ff <= '0;
                        idx_ff   <= '0;
                        any_ff   <= 1'b0;
                        cnt_ff   <= '0;
                        state_ff <= ST_SWEEP;
                     end else begin
                        ticks_ff <= ticks_nx;
                     end
                  end
               end
            end
            ST_LOOK: state_ff <= ST_DECIDE;
            ST_DECIDE: begin
               if (hit_any) begin
                  idx_ff   <= hit_idx;
                  upd_ff   <= 1'b1;
                  rsp_kind <= KIND_UPD;
                  state_ff <= ST_WRITE;
               end else if (free_any) begin
                  idx_ff   <= free_idx;
                  new_ff   <= 1'b1;
                  rsp_kind <= KIND_NEW;
                  state_ff <= ST_WRITE;
               end else begin
                  rsp_strobe <= 1'b1;
                  rsp_kind   <= KIND_FULL;
                  rsp_flow_source <= src_ff; rsp_flow_dest <= dst_ff;
                  rsp_flow_proto <= pr_ff; rsp_byte_total <= '0;
                  rsp_packet_total <= '0; rsp_src_port_tally <= '0;
                  rsp_dst_port_tally <= '0; rsp_start_second <= '0;
                  rsp_duration_seconds <= '0;
                  rsp_last   <= 1'b1;
                  state_ff   <= ST_IDLE;
               end
            end
            // selected cell takes the update or the new flow
            ST_WRITE: state_ff <= ST_EMIT;
            ST_EMIT: begin
               // cell now holds updated contents
               rsp_strobe <= 1'b1;
               rsp_flow_source <= cur.source; rsp_flow_dest <= cur.dest;
               rsp_flow_proto <= cur.proto; rsp_byte_total <= cur.bytes;
               rsp_packet_total <= cur.packets; rsp_src_port_tally <= cur.src_tally;
               rsp_dst_port_tally <= cur.dst_tally; rsp_start_second <= cur.start;
               rsp_duration_seconds <= cur.last_seen - cur.start;
               rsp_last   <= 1'b1;
               state_ff   <= ST_IDLE;
            end
            ST_SWEEP: begin
               // one slot per cycle; last when no expired slot follows or at the cap
               if (take) begin
                  rsp_strobe <= 1'b1;
                  rsp_kind   <= stat[idx_ff].idle ? KIND_IDLE : KIND_ACTIVE;
                  rsp_flow_source <= cur.source; rsp_flow_dest <= cur.dest;
                  rsp_flow_proto <= cur.proto; rsp_byte_total <= cur.bytes;
                  rsp_packet_total <= cur.packets;
                  rsp_src_port_tally <= cur.src_tally;
                  rsp_dst_port_tally <= cur.dst_tally; rsp_start_second <= cur.start;
                  rsp_duration_seconds <= cur.last_seen - cur.start;
                  rsp_last   <= !more_after || cnt_ff == 6'(MAX_EVICT - 1);
                  any_ff     <= 1'b1;
                  cnt_ff     <= cnt_ff + 6'd1;
               end
               if (last_slot) state_ff <= ST_SWEND;
               else idx_ff <= idx_ff + IW'(1);
            end
            ST_SWEND: begin
               // empty marker only when nothing was evicted
               if (!any_ff) begin
                  rsp_strobe <= 1'b1;
                  rsp_last   <= 1'b1;
                  rsp_kind   <= KIND_EMPTY;
                  rsp_flow_source <= '0; rsp_flow_dest <= '0;
                  rsp_flow_proto <= '0; rsp_byte_total <= '0;
                  rsp_packet_total <= '0; rsp_src_port_tally <= '0;
                  rsp_dst_port_tally <= '0; rsp_start_second <= '0;
                  rsp_duration_seconds <= '0;
               end
               state_ff   <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // checks
   a_no_strobe_look: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOK |=> !rsp_strobe) else $error("strobe during lookup");
   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_v)) else $error("multiple matching flows");
   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      busy && $past(!busy) |-> $past(start)) else $error("busy without start");

endmodule

/* dv/flow_table_checker.sv */
// flow table checker: predicts expected records and compares the result channel
module flow_table_checker
   import ftt_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_command,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_dest_address,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   input  logic [15:0] req_packet_bytes,
   input  logic [7:0]  req_proto,
   input  logic        rsp_strobe,
   input  logic [2:0]  rsp_kind,
   input  logic [31:0] rsp_flow_source,
   input  logic [31:0] rsp_flow_dest,
   input  logic [7:0]  rsp_flow_proto,
   input  logic [39:0] rsp_byte_total,
   input  logic [31:0] rsp_packet_total,
   input  logic [15:0] rsp_src_port_tally,
   input  logic [15:0] rsp_dst_port_tally,
   input  logic [31:0] rsp_start_second,
   input  logic [31:0] rsp_duration_seconds,
   input  logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          failures,
   output int          outstanding,
   output int          records_checked,
   output int          evictions_seen
);

   localparam int MAX_EVICT = 32;

   typedef struct {
      kind_type    kind;
      logic [31:0] source;
      logic [31:0] dest;
      logic [7:0]  proto;
      logic [39:0] bytes;
      logic [31:0] packets;
      logic [15:0] src_tally;
      logic [15:0] dst_tally;
      logic [31:0] start_sec;
      logic [31:0] duration;
      logic        last;
   } flow_record_type;

   flow_record_type expected_records[$];

   // shadow of the flow table
   logic        flow_valid[TABLE_DEPTH];
   slot_type    flow_slot[TABLE_DEPTH];
   logic [31:0] seconds_now;
   logic [15:0] ticks_pending;

   // shadow of the registers
   logic [31:0] cfg_local_ip;
   logic [15:0] cfg_idle;
   logic [15:0] cfg_active;
   logic [15:0] cfg_refresh;

   assign outstanding = expected_records.size();

   function automatic flow_record_type blank_record(kind_type k);
      flow_record_type r;
      r.kind = k;
      r.source = '0;
      r.dest = '0;
      r.proto = '0;
      r.bytes = '0;
      r.packets = '0;
      r.src_tally = '0;
      r.dst_tally = '0;
      r.start_sec = '0;
      r.duration = '0;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic flow_record_type slot_record(kind_type k, int s);
      flow_record_type r;
      r = blank_record(k);
      r.source = flow_slot[s].source;
      r.dest = flow_slot[s].dest;
      r.proto = flow_slot[s].proto;
      r.bytes = flow_slot[s].bytes;
      r.packets = flow_slot[s].packets;
      r.src_tally = flow_slot[s].src_tally;
      r.dst_tally = flow_slot[s].dst_tally;
      r.start_sec = flow_slot[s].start;
      r.duration = flow_slot[s].last_seen - flow_slot[s].start;
      return r;
   endfunction

   // lookup, update or create for one packet
   function automatic void predict_packet(logic [31:0] src, logic [31:0] dst,
                                          logic [15:0] sp, logic [15:0] dp,
                                          logic [15:0] len, logic [7:0] pr);
      logic [31:0]     klo;
      logic [31:0]     khi;
      int              hit;
      int              free_slot;
      flow_record_type r;
      hit = -1;
      free_slot = -1;
      if (dst != cfg_local_ip) begin
         r = blank_record(KIND_SKIP);
         r.last = 1'b1;
         expected_records.push_back(r);
         return;
      end
      if (src < dst) begin
         klo = src;
         khi = dst;
      end else begin
         klo = dst;
         khi = src;
      end
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         if (flow_valid[s]) begin
            if (hit < 0 && flow_slot[s].key_low == klo && flow_slot[s].key_high == khi &&
                flow_slot[s].proto == pr)
               hit = s;
         end else if (free_slot < 0) begin
            free_slot = s;
         end
      end
      if (hit >= 0) begin
         if (flow_slot[hit].bytes > BYTE_MAX - {24'd0, len})
            flow_slot[hit].bytes = BYTE_MAX;
         else
            flow_slot[hit].bytes = flow_slot[hit].bytes + {24'd0, len};
         if (flow_slot[hit].packets != PKT_MAX)
            flow_slot[hit].packets++;
         flow_slot[hit].last_seen = seconds_now;
         if (flow_slot[hit].src_tally == 0 || flow_slot[hit].src_tally < sp)
            flow_slot[hit].src_tally++;
         if (flow_slot[hit].dst_tally == 0 || flow_slot[hit].dst_tally < dp)
            flow_slot[hit].dst_tally++;
         r = slot_record(KIND_UPD, hit);
      end else if (free_slot >= 0) begin
         flow_valid[free_slot] = 1'b1;
         flow_slot[free_slot].key_low = klo;
         flow_slot[free_slot].key_high = khi;
         flow_slot[free_slot].proto = pr;
         flow_slot[free_slot].source = src;
         flow_slot[free_slot].dest = dst;
         flow_slot[free_slot].bytes = {24'd0, len};
         flow_slot[free_slot].packets = 32'd1;
         flow_slot[free_slot].src_tally = 16'd1;
         flow_slot[free_slot].dst_tally = 16'd1;
         flow_slot[free_slot].start = seconds_now;
         flow_slot[free_slot].last_seen = seconds_now;
         r = slot_record(KIND_NEW, free_slot);
      end else begin
         r = blank_record(KIND_FULL);
         r.source = src;
         r.dest = dst;
         r.proto = pr;
      end
      r.last = 1'b1;
      expected_records.push_back(r);
   endfunction

   // one-second tick, with a timeout sweep every refresh period
   function automatic void predict_tick();
      logic [15:0] period;
      int          evicted;
      kind_type    k;
      evicted = 0;
      seconds_now++;
      period = (cfg_refresh == 0) ? 16'd1 : cfg_refresh;
      ticks_pending++;
      if (ticks_pending < period)
         return;
      ticks_pending = '0;
      for (int s = 0; s < TABLE_DEPTH && evicted < MAX_EVICT; s++) begin
         if (!flow_valid[s])
            continue;
         if (seconds_now - flow_slot[s].last_seen >= {16'd0, cfg_idle})
            k = KIND_IDLE;
         else if (seconds_now - flow_slot[s].start >= {16'd0, cfg_active})
            k = KIND_ACTIVE;
         else
            continue;
         expected_records.push_back(slot_record(k, s));
         flow_valid[s] = 1'b0;
         evicted++;
      end
      if (evicted == 0)
         expected_records.push_back(blank_record(KIND_EMPTY));
      expected_records[expected_records.size() - 1].last = 1'b1;
   endfunction

   function automatic void compare_field(string name, logic [39:0] exp_v, logic [39:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      flow_record_type e;
      if (reset) begin
         for (int s = 0; s < TABLE_DEPTH; s++) begin
            flow_valid[s] <= 1'b0;
            flow_slot[s] <= '0;
         end
         seconds_now <= '0;
         ticks_pending <= '0;
         cfg_local_ip <= '0;
         cfg_idle <= 16'd60;
         cfg_active <= 16'd300;
         cfg_refresh <= 16'd5;
         expected_records.delete();
         failures <= 0;
         records_checked <= 0;
         evictions_seen <= 0;
      end else begin
         // result transaction against the oldest expectation
         if (rsp_strobe) begin
            records_checked++;
            if (rsp_kind == KIND_IDLE || rsp_kind == KIND_ACTIVE)
               evictions_seen++;
            if (expected_records.size() == 0) begin
               $error("rsp: unexpected record, kind %0d", rsp_kind);
               failures++;
            end else begin
               e = expected_records.pop_front();
               compare_field("rsp_kind", 40'(e.kind), 40'(rsp_kind));
               compare_field("rsp_flow_source", 40'(e.source), 40'(rsp_flow_source));
               compare_field("rsp_flow_dest", 40'(e.dest), 40'(rsp_flow_dest));
               compare_field("rsp_flow_proto", 40'(e.proto), 40'(rsp_flow_proto));
               compare_field("rsp_byte_total", e.bytes, rsp_byte_total);
               compare_field("rsp_packet_total", 40'(e.packets), 40'(rsp_packet_total));
               compare_field("rsp_src_port_tally", 40'(e.src_tally),
                             40'(rsp_src_port_tally));
               compare_field("rsp_dst_port_tally", 40'(e.dst_tally),
                             40'(rsp_dst_port_tally));
               compare_field("rsp_start_second", 40'(e.start_sec), 40'(rsp_start_second));
               compare_field("rsp_duration_seconds", 40'(e.duration),
                             40'(rsp_duration_seconds));
               compare_field("rsp_last", 40'(e.last), 40'(rsp_last));
            end
         end
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_LOCAL_IP: cfg_local_ip = csr_data;
               CSR_IDLE:     cfg_idle = csr_data[15:0];
               CSR_ACTIVE:   cfg_active = csr_data[15:0];
               CSR_REFRESH:  cfg_refresh = csr_data[15:0];
               default: ;
            endcase
         end
         // accepted input transaction
         if (start && !busy) begin
            if (req_command)
               predict_tick();
            else
               predict_packet(req_source_address, req_dest_address, req_source_port,
                              req_dest_port, req_packet_bytes, req_proto);
         end
      end
   end

endmodule

/* dv/tb_flow_table_with_timeouts_top.sv */
// testbench top for the flow table: stimulus, watchdog and verdict
module tb_flow_table_with_timeouts_top;
   import ftt_pkg::*;

   localparam int TABLE_DEPTH = 32;
   localparam int PHASE_ITEMS = 80;
   localparam int POOL_SIZE = 40;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 10;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_command;
   logic [31:0] req_source_address;
   logic [31:0] req_dest_address;
   logic [15:0] req_source_port;
   logic [15:0] req_dest_port;
   logic [15:0] req_packet_bytes;
   logic [7:0]  req_proto;
   logic        rsp_strobe;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_flow_source;
   logic [31:0] rsp_flow_dest;
   logic [7:0]  rsp_flow_proto;
   logic [39:0] rsp_byte_total;
   logic [31:0] rsp_packet_total;
   logic [15:0] rsp_src_port_tally;
   logic [15:0] rsp_dst_port_tally;
   logic [31:0] rsp_start_second;
   logic [31:0] rsp_duration_seconds;
   logic        rsp_last;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   int failures;
   int outstanding;
   int records_checked;
   int evictions_seen;
   int items_sent;
   int stall_cycles;
   int gap_mode_burst;
   logic [31:0] host_ip;
   logic [31:0] src_pool[POOL_SIZE];

   flow_table_with_timeouts_top #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (.*);

   flow_table_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // one input transaction, after a random gap unless in a burst
   task automatic send_item(logic cmd, logic [31:0] src, logic [31:0] dst, logic [15:0] sp,
                            logic [15:0] dp, logic [15:0] len, logic [7:0] pr);
      int gap;
      gap = gap_mode_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_source_address <= src;
      req_dest_address <= dst;
      req_source_port <= sp;
      req_dest_port <= dp;
      req_packet_bytes <= len;
      req_proto <= pr;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic send_tick();
      send_item(1'b1, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                8'($urandom));
   endtask

   // wait for the block to drain, then write all four registers
   task automatic set_config(logic [31:0] lip, logic [15:0] idle_s, logic [15:0] act_s,
                             logic [15:0] refresh);
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_LOCAL_IP;
      csr_data <= lip;
      @(posedge clock);
      csr_index <= CSR_IDLE;
      csr_data <= {16'd0, idle_s};
      @(posedge clock);
      csr_index <= CSR_ACTIVE;
      csr_data <= {16'd0, act_s};
      @(posedge clock);
      csr_index <= CSR_REFRESH;
      csr_data <= {16'd0, refresh};
      @(posedge clock);
      csr_we <= 1'b0;
      host_ip = lip;
   endtask

   // mostly packets from a pool of flows to the local address, some noise and ticks
   task automatic run_phase(int tick_pct);
      int pick;
      logic [7:0] pr;
      for (int i = 0; i < POOL_SIZE; i++)
         src_pool[i] = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         gap_mode_burst = (n / 20) % 2;
         pick = $urandom_range(0, 99);
         case ($urandom_range(0, 3))
            0: pr = 8'd6;
            1: pr = 8'd17;
            2: pr = 8'd1;
            default: pr = 8'($urandom);
         endcase
         if (pick < tick_pct)
            send_tick();
         else if (pick < tick_pct + 8)
            send_item(1'b0, $urandom, $urandom, 16'($urandom), 16'($urandom),
                      16'($urandom), 8'($urandom));
         else if (pick < tick_pct + 12)
            send_item(1'b0, $urandom, host_ip, 16'($urandom), 16'($urandom),
                      16'($urandom), 8'($urandom));
         else
            send_item(1'b0, src_pool[$urandom_range(0, POOL_SIZE - 1)], host_ip,
                      16'($urandom), 16'($urandom), 16'($urandom), pr);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_command = 1'b0;
      req_source_address = '0;
      req_dest_address = '0;
      req_source_port = '0;
      req_dest_port = '0;
      req_packet_bytes = '0;
      req_proto = '0;
      csr_we = 1'b0;
      csr_index = CSR_LOCAL_IP;
      csr_data = '0;
      items_sent = 0;
      gap_mode_burst = 0;
      host_ip = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under reset register values
      send_item(1'b0, 32'h5, 32'h0, 16'h0, 16'h0, 16'h0, 8'h0);
      send_item(1'b0, 32'h5, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h0);
      send_item(1'b0, 32'h5, 32'h0, 16'h0, 16'h0, 16'h1, 8'h0);
      send_item(1'b0, 32'h5, 32'h0, 16'h0, 16'h0, 16'h1, 8'h0);
      send_item(1'b0, 32'h5, 32'h0, 16'h1, 16'h1, 16'h7, 8'hFF);
      send_item(1'b0, 32'hFFFF_FFFF, 32'h0, 16'h8000, 16'h0001, 16'hFFFF, 8'hFF);
      send_item(1'b0, 32'h0, 32'h0, 16'h2, 16'h3, 16'h0, 8'h11);
      send_item(1'b0, 32'h1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      for (int t = 0; t < 5; t++)
         send_tick();
      send_item(1'b0, 32'h5, 32'h0, 16'h10, 16'h10, 16'h40, 8'h0);

      // short timeouts: idle evictions
      set_config(32'h0A00_0001, 16'd1, 16'd2, 16'd1);
      send_item(1'b0, 32'h0A00_0002, 32'h0A00_0001, 16'd80, 16'd443, 16'd100, 8'd6);
      send_tick();
      send_item(1'b0, 32'h0A00_0002, 32'h0A00_0001, 16'd80, 16'd443, 16'd100, 8'd6);
      send_tick();
      send_tick();

      // random phases over several register settings, extremes included
      set_config(32'h0, 16'd60, 16'd300, 16'd5);
      run_phase(15);
      set_config($urandom, 16'd3, 16'd8, 16'd2);
      run_phase(20);
      set_config(32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0);
      run_phase(10);
      set_config($urandom, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_phase(5);
      set_config($urandom, 16'd5, 16'd2, 16'd1);
      run_phase(20);
      set_config($urandom, 16'd1, 16'd1, 16'd3);
      run_phase(25);

      // drain
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d input transactions and %0d result records (%0d evictions)",
               items_sent, records_checked, evictions_seen);
      $display("over eight register settings including zero and all-ones limits");
      if (failures == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
